/* design/pfdm_pkg.sv */
package pfdm_pkg;

	// Fixed field widths
	localparam int CLOCK_BITS = 27;
	localparam int DUTY_BITS  = 14;
	localparam int SCALE_BITS = 14;

	// Duty scale: hundredths of a percent
	localparam logic [SCALE_BITS-1:0] DUTY_SCALE  = 14'd10000;
	localparam logic [CLOCK_BITS-1:0] CLOCK_RESET = 27'd16000000;

	// Capture phase: which edge the current capture belongs to
	typedef enum logic [1:0] {
		PH_FIRST_RISE = 2'd0,
		PH_FALL       = 2'd1,
		PH_SECOND_RISE = 2'd2
	} phase_t;

	// Sequencer state
	typedef enum logic [2:0] {
		ST_IDLE      = 3'd0,
		ST_FREQ_GO   = 3'd1,
		ST_FREQ_WAIT = 3'd2,
		ST_DUTY_GO   = 3'd3,
		ST_DUTY_WAIT = 3'd4
	} state_t;

endpackage

/* design/pfdm_div.sv */
module pfdm_div #(
	parameter int DIVIDEND_BITS = 30,
	parameter int DIVISOR_BITS  = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [DIVIDEND_BITS-1:0] dividend,
	input  logic [DIVISOR_BITS-1:0]  divisor,
	output logic                     done,
	output logic [DIVIDEND_BITS-1:0] quotient
);

	localparam int CNT_BITS = (DIVIDEND_BITS > 2) ? $clog2(DIVIDEND_BITS) : 1;
	localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(DIVIDEND_BITS - 1);

	logic                     busy_q;
	logic                     done_q;
	logic [CNT_BITS-1:0]      cnt_q;
	logic [DIVISOR_BITS-1:0]  rem_q;
	logic [DIVISOR_BITS-1:0]  divisor_q;
	logic [DIVIDEND_BITS-1:0] quo_q;

	logic [DIVISOR_BITS:0]    trial;
	logic [DIVISOR_BITS:0]    diff;
	logic                     fits;
	logic [DIVISOR_BITS-1:0]  rem_d;
	logic [DIVIDEND_BITS-1:0] quo_d;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q, quo_q[DIVIDEND_BITS-1]};
		diff  = trial - {1'b0, divisor_q};
		fits  = (trial >= {1'b0, divisor_q});
		rem_d = fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
		quo_d = {quo_q[DIVIDEND_BITS-2:0], fits};
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			quo_q     <= dividend;
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_d;
			quo_q <= quo_d;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* design/pwm_frequency_duty_meter_core.sv */
// Channel  | handshake         | payload
// ---------+-------------------+--------------------------------------------------
// cfg      | cfg_we            | cfg_wdata (clock_hz)
// in       | in_valid/in_stall | capture_count
// out      | out_valid/out_stall | arm_rising, measurement_updated, frequency_hz,
//          |                   |   duty_hundredths
//
// A first-rise, falling or rejected capture gives its result in the cycle after the transfer.
// A completed measurement runs two divisions on one radix-2 divider, one quotient bit per
// cycle, and gives its result when the duty division is done.
// One item is in work at a time; in_stall stays high until its result is transferred.
// Reset sets clock_hz to 16000000 and clears phase and held measurements.
module pwm_frequency_duty_meter_core #(
	parameter int COUNT_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pfdm_pkg::CLOCK_BITS-1:0]     cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [COUNT_BITS-1:0]               capture_count,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                arm_rising,
	output logic                                measurement_updated,
	output logic [pfdm_pkg::CLOCK_BITS-1:0]     frequency_hz,
	output logic [pfdm_pkg::DUTY_BITS-1:0]      duty_hundredths
);

	import pfdm_pkg::*;

	localparam int PROD_BITS = COUNT_BITS + SCALE_BITS;
	localparam int DIV_BITS  = (PROD_BITS > CLOCK_BITS) ? PROD_BITS : CLOCK_BITS;

	state_t                  state_q, state_d;
	phase_t                  phase_q;
	logic [CLOCK_BITS-1:0]   clock_hz_q;
	logic [COUNT_BITS-1:0]   first_rise_q;
	logic [COUNT_BITS-1:0]   fall_q;
	logic [COUNT_BITS-1:0]   period_q;
	logic [COUNT_BITS-1:0]   high_q;
	logic [PROD_BITS-1:0]    product_q;
	logic [CLOCK_BITS-1:0]   held_freq_q;
	logic [DUTY_BITS-1:0]    held_duty_q;
	logic                    out_valid_q;
	logic                    arm_q;
	logic                    updated_q;

	logic                    in_xfer;
	logic                    out_xfer;
	logic                    stamps_ok;
	logic                    div_start;
	logic [DIV_BITS-1:0]     div_dividend;
	logic                    div_done;
	logic [DIV_BITS-1:0]     div_quotient;

	assign in_stall  = (state_q != ST_IDLE) || out_valid_q;
	assign in_xfer   = in_valid && !in_stall;
	assign out_xfer  = out_valid_q && !out_stall;
	assign stamps_ok = (first_rise_q < fall_q) && (fall_q < capture_count);

	// Sequencer: next state and divider control
	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		div_dividend = DIV_BITS'(clock_hz_q);
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer && phase_q == PH_SECOND_RISE && stamps_ok) begin
					state_d = ST_FREQ_GO;
				end
			end
			ST_FREQ_GO: begin
				div_start = 1'b1;
				state_d   = ST_FREQ_WAIT;
			end
			ST_FREQ_WAIT: begin
				if (div_done) begin
					state_d = ST_DUTY_GO;
				end
			end
			ST_DUTY_GO: begin
				div_start    = 1'b1;
				div_dividend = DIV_BITS'(product_q);
				state_d      = ST_DUTY_WAIT;
			end
			ST_DUTY_WAIT: begin
				if (div_done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= CLOCK_RESET;
		end else if (cfg_we) begin
			clock_hz_q <= cfg_wdata;
		end
	end

	// Phase, stamps, held measurements and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_FIRST_RISE;
			first_rise_q <= '0;
			fall_q       <= '0;
			held_freq_q  <= '0;
			held_duty_q  <= '0;
			out_valid_q  <= 1'b0;
			arm_q        <= 1'b0;
			updated_q    <= 1'b0;
		end else begin
			if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
			if (in_xfer) begin
				unique case (phase_q)
					PH_FALL: begin
						fall_q      <= capture_count;
						phase_q     <= PH_SECOND_RISE;
						arm_q       <= 1'b1;
						updated_q   <= 1'b0;
						out_valid_q <= 1'b1;
					end
					PH_SECOND_RISE: begin
						phase_q   <= PH_FIRST_RISE;
						arm_q     <= 1'b1;
						updated_q <= stamps_ok;
						// hold the result back until both divisions finish
						out_valid_q <= !stamps_ok;
					end
					default: begin
						first_rise_q <= capture_count;
						phase_q      <= PH_FALL;
						arm_q        <= 1'b0;
						updated_q    <= 1'b0;
						out_valid_q  <= 1'b1;
					end
				endcase
			end
			if (state_q == ST_FREQ_WAIT && div_done) begin
				held_freq_q <= div_quotient[CLOCK_BITS-1:0];
			end
			if (state_q == ST_DUTY_WAIT && div_done) begin
				held_duty_q <= div_quotient[DUTY_BITS-1:0];
				out_valid_q <= 1'b1;
			end
		end
	end

	// Period, high time and scaled high time
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			period_q <= capture_count - first_rise_q;
			high_q   <= fall_q - first_rise_q;
		end
		if (state_q == ST_FREQ_GO) begin
			product_q <= PROD_BITS'(high_q) * PROD_BITS'(DUTY_SCALE);
		end
	end

	pfdm_div #(
		.DIVIDEND_BITS(DIV_BITS),
		.DIVISOR_BITS (COUNT_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (period_q),
		.done    (div_done),
		.quotient(div_quotient)
	);

	assign out_valid           = out_valid_q;
	assign arm_rising          = arm_q;
	assign measurement_updated = updated_q;
	assign frequency_hz        = held_freq_q;
	assign duty_hundredths     = held_duty_q;

	// A result appears only after an immediate capture or the duty division
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(in_xfer) || $past(state_q) == ST_DUTY_WAIT))
		else $error("result raised without a source");

	// A completed measurement always re-arms the rising edge
	a_update_arm: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && updated_q) |-> arm_q)
		else $error("measurement reported with falling edge armed");

	// Divider finishes only while the sequencer waits on it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_FREQ_WAIT || state_q == ST_DUTY_WAIT))
		else $error("divider done outside a wait state");

	// Duty stays below full scale
	a_duty_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (held_duty_q < DUTY_SCALE))
		else $error("duty out of range");

endmodule

/* dv/tb_pwm_frequency_duty_meter_core.sv */
`timescale 1ns / 100ps

module tb_pwm_frequency_duty_meter_core;
	import pfdm_pkg::*;

	localparam int COUNT_BITS = 16;
	localparam int TRIPLES_PER_SETTING = 105;
	localparam int DIVIDE_LATENCY = 2 * 30 + 4;
	localparam int LONG_HOLD = 300;
	localparam int LONG_HOLD_AT = 500;

	typedef logic [COUNT_BITS-1:0] stamp_t;
	typedef logic [CLOCK_BITS-1:0] clock_t;

	typedef struct packed {
		logic                  arm_rising;
		logic                  updated;
		logic [CLOCK_BITS-1:0] frequency;
		logic [DUTY_BITS-1:0]  duty;
	} reading_t;

	// Predict each reading from the capture sequence and check the block's output
	class meter_scoreboard;
		clock_t   clock_hz;
		phase_t   phase;
		stamp_t   rise_stamp;
		stamp_t   fall_stamp;
		clock_t   held_frequency;
		logic [DUTY_BITS-1:0] held_duty;
		reading_t expected_readings[$];
		int       mismatch_count;

		function new();
			clock_hz = CLOCK_RESET;
			phase = PH_FIRST_RISE;
			rise_stamp = '0;
			fall_stamp = '0;
			held_frequency = '0;
			held_duty = '0;
			mismatch_count = 0;
		endfunction

		function void set_clock(clock_t value);
			clock_hz = value;
		endfunction

		function int pending();
			return expected_readings.size();
		endfunction

		function void note_capture(stamp_t stamp);
			reading_t r;
			longint unsigned period;
			longint unsigned high_time;
			r.arm_rising = 1'b1;
			r.updated = 1'b0;
			case (phase)
				PH_FALL: begin
					fall_stamp = stamp;
					phase = PH_SECOND_RISE;
				end
				PH_SECOND_RISE: begin
					// measure only when the three stamps rise strictly
					if (rise_stamp < fall_stamp && fall_stamp < stamp) begin
						period = longint'(stamp) - longint'(rise_stamp);
						high_time = longint'(fall_stamp) - longint'(rise_stamp);
						held_frequency = clock_t'(longint'(clock_hz) / period);
						held_duty = DUTY_BITS'((high_time * 10000) / period);
						r.updated = 1'b1;
					end
					phase = PH_FIRST_RISE;
				end
				default: begin
					rise_stamp = stamp;
					r.arm_rising = 1'b0;
					phase = PH_FALL;
				end
			endcase
			r.frequency = held_frequency;
			r.duty = held_duty;
			expected_readings.push_back(r);
		endfunction

		function void check_reading(reading_t got);
			reading_t exp_r;
			if (expected_readings.size() == 0) begin
				$error("reading with no capture pending: arm %0d upd %0d freq %0d duty %0d",
					got.arm_rising, got.updated, got.frequency, got.duty);
				mismatch_count++;
				return;
			end
			exp_r = expected_readings.pop_front();
			if (got.arm_rising !== exp_r.arm_rising) begin
				$error("arm_rising: expected %0d, actual %0d", exp_r.arm_rising, got.arm_rising);
				mismatch_count++;
			end
			if (got.updated !== exp_r.updated) begin
				$error("measurement_updated: expected %0d, actual %0d",
					exp_r.updated, got.updated);
				mismatch_count++;
			end
			if (got.frequency !== exp_r.frequency) begin
				$error("frequency_hz: expected %0d, actual %0d", exp_r.frequency, got.frequency);
				mismatch_count++;
			end
			if (got.duty !== exp_r.duty) begin
				$error("duty_hundredths: expected %0d, actual %0d", exp_r.duty, got.duty);
				mismatch_count++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	clock_t                cfg_wdata;
	logic                  in_valid;
	logic                  in_stall;
	stamp_t                capture_count;
	logic                  out_valid;
	logic                  out_stall;
	logic                  arm_rising;
	logic                  measurement_updated;
	clock_t                frequency_hz;
	logic [DUTY_BITS-1:0]  duty_hundredths;

	meter_scoreboard sb;
	bit no_idle;

	pwm_frequency_duty_meter_core #(
		.COUNT_BITS(COUNT_BITS)
	) uut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_wdata           (cfg_wdata),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.capture_count       (capture_count),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.arm_rising          (arm_rising),
		.measurement_updated (measurement_updated),
		.frequency_hz        (frequency_hz),
		.duty_hundredths     (duty_hundredths)
	);

	always #5 clk = ~clk;

	function automatic int idle_draw();
		return no_idle ? 0 : $urandom_range(0, 4);
	endfunction

	// Offer one capture from a falling edge; return at the falling edge after the transfer
	task automatic send_capture(stamp_t stamp);
		int gap;
		gap = idle_draw();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		capture_count <= stamp;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_capture(stamp);
		@(negedge clk);
	endtask

	task automatic send_triple(stamp_t rise1, stamp_t fall, stamp_t rise2);
		send_capture(rise1);
		send_capture(fall);
		send_capture(rise2);
		no_idle = ($urandom_range(0, 7) == 0);
	endtask

	// Mostly well-formed edge sequences; some noise and some wrapped timers
	task automatic random_triple();
		int kind;
		int r1;
		int span;
		int per;
		stamp_t f;
		stamp_t r2;
		kind = $urandom_range(0, 9);
		if (kind < 8) begin
			r1 = $urandom_range(0, 65533);
			span = 65535 - r1;
			if ($urandom_range(0, 3) == 0 && span > 64) span = 64;
			per = $urandom_range(2, span);
			f = stamp_t'(r1 + $urandom_range(1, per - 1));
			r2 = stamp_t'(r1 + per);
			send_triple(stamp_t'(r1), f, r2);
		end else if (kind == 8) begin
			send_triple(stamp_t'($urandom), stamp_t'($urandom), stamp_t'($urandom));
		end else begin
			r1 = $urandom_range(0, 65535);
			send_triple(stamp_t'(r1), stamp_t'($urandom), stamp_t'($urandom_range(0, r1)));
		end
	endtask

	// Write clock_hz only once the block has drained
	task automatic write_clock(clock_t value);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (DIVIDE_LATENCY + 6) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_clock(value);
	endtask

	// Drive captures: directed sequences, then random phases at several clock settings
	initial begin : capture_source
		clock_t settings[5];
		int wait_cycles;
		settings[0] = clock_t'(1);
		settings[1] = '1;
		settings[2] = clock_t'(100000000);
		settings[3] = clock_t'($urandom_range(1, 2 ** CLOCK_BITS - 1));
		settings[4] = CLOCK_RESET;
		sb = new();
		no_idle = 1'b0;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		capture_count = '0;
		out_stall = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// shortest period, widest duty, longest period
		send_triple(16'd0, 16'd1, 16'd2);
		send_triple(16'd0, 16'd65534, 16'd65535);
		send_triple(16'd0, 16'd1, 16'd65535);
		// falling stamp behind the first rise, second rise behind the fall
		send_triple(16'd100, 16'd50, 16'd200);
		send_triple(16'd100, 16'd200, 16'd150);
		// equal stamps are not strictly rising
		send_triple(16'd5, 16'd5, 16'd10);
		send_triple(16'd5, 16'd10, 16'd10);
		// timer wrap between captures
		send_triple(16'd65535, 16'd0, 16'd65535);

		foreach (settings[s]) begin
			write_clock(settings[s]);
			repeat (TRIPLES_PER_SETTING) random_triple();
		end

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		wait_cycles = 0;
		while (wait_cycles < DIVIDE_LATENCY + 10) begin
			@(negedge clk);
			wait_cycles++;
		end
		if (sb.mismatch_count == 0 && sb.pending() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Accept readings with random stalls, plus one long hold-off to back up the input
	initial begin : reading_sink
		int hold;
		int taken;
		reading_t got;
		taken = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			hold = idle_draw();
			if (taken == LONG_HOLD_AT) hold = LONG_HOLD;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			got.arm_rising = arm_rising;
			got.updated = measurement_updated;
			got.frequency = frequency_hz;
			got.duty = duty_hundredths;
			sb.check_reading(got);
			taken++;
		end
	end

	// Drop the run if it hangs
	initial begin : watchdog
		#8_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
